// ----- design/delayed_task_release_queue_unit_defines.svh -----
// assertion macros for the delayed task release queue
`ifndef DELAYED_TASK_RELEASE_QUEUE_UNIT_DEFINES_SVH
`define DELAYED_TASK_RELEASE_QUEUE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define DTRQ_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dtrq assertion failed: same cycle");
`define DTRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dtrq assertion failed: next cycle");
`else
`define DTRQ_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTRQ_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/dtrq_pkg.sv -----
package dtrq_pkg;

   localparam int MaxTasks = 16;
   localparam int IdxW     = $clog2(MaxTasks);
   localparam int CountW   = $clog2(MaxTasks + 1);
   localparam int TaskIdW  = 4;
   localparam int TimeW    = 32;

   localparam logic FuncEnqueue = 1'b0;
   localparam logic FuncTick    = 1'b1;

   localparam logic [1:0] ListNop    = 2'd0;
   localparam logic [1:0] ListRemove = 2'd1;
   localparam logic [1:0] ListInsert = 2'd2;

   typedef struct packed {
      logic               func;
      logic [TaskIdW-1:0] task_id;
      logic [TimeW-1:0]   arrival_time;
      logic [TimeW-1:0]   current_tick;
   } req_type;

   typedef struct packed {
      logic [TaskIdW-1:0] started_task;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [IdxW-1:0]    pos;
      logic [TaskIdW-1:0] id;
      logic [TimeW-1:0]   stamp;
   } list_cmd_type;

endpackage

// ----- design/dtrq_list.sv -----
module dtrq_list import dtrq_pkg::*; (
   input  logic               clock,
   input  list_cmd_type       cmd,
   input  logic [IdxW-1:0]    rd_idx,
   output logic [TaskIdW-1:0] rd_id,
   output logic [TimeW-1:0]   rd_time,
   output logic [TaskIdW-1:0] head_id,
   output logic [TimeW-1:0]   head_time
);

   logic [TaskIdW-1:0] ids_ff   [MaxTasks];
   logic [TimeW-1:0]   times_ff [MaxTasks];
   logic [TaskIdW-1:0] ids_in   [MaxTasks];
   logic [TimeW-1:0]   times_in [MaxTasks];

   for (genvar g = 0; g < MaxTasks; g++) begin : g_entry
      logic [TaskIdW-1:0] up_id;
      logic [TimeW-1:0]   up_time;
      logic [TaskIdW-1:0] down_id;
      logic [TimeW-1:0]   down_time;

      // neighbor toward the tail, used when an entry is removed
      if (g < MaxTasks - 1) begin : g_up
         assign up_id   = ids_ff[g + 1];
         assign up_time = times_ff[g + 1];
      end else begin : g_up_end
         assign up_id   = ids_ff[g];
         assign up_time = times_ff[g];
      end

      // neighbor toward the head, used when an entry is inserted
      if (g > 0) begin : g_down
         assign down_id   = ids_ff[g - 1];
         assign down_time = times_ff[g - 1];
      end else begin : g_down_end
         assign down_id   = ids_ff[g];
         assign down_time = times_ff[g];
      end

      always_comb begin
         ids_in[g]   = ids_ff[g];
         times_in[g] = times_ff[g];
         unique case (cmd.op)
            ListRemove: begin
               if (IdxW'(g) >= cmd.pos) begin
                  ids_in[g]   = up_id;
                  times_in[g] = up_time;
               end
            end
            ListInsert: begin
               if (IdxW'(g) == cmd.pos) begin
                  ids_in[g]   = cmd.id;
                  times_in[g] = cmd.stamp;
               end else if (IdxW'(g) > cmd.pos) begin
                  ids_in[g]   = down_id;
                  times_in[g] = down_time;
               end
            end
            default: begin
            end
         endcase
      end

      always_ff @(posedge clock) begin
         ids_ff[g]   <= ids_in[g];
         times_ff[g] <= times_in[g];
      end
   end

   assign rd_id     = ids_ff[rd_idx];
   assign rd_time   = times_ff[rd_idx];
   assign head_id   = ids_ff[0];
   assign head_time = times_ff[0];

endmodule

// ----- design/delayed_task_release_queue_unit.sv -----
// Sorted release queue for up to MaxTasks delayed tasks, one entry per task id. An enqueue
// item (func 0) drops any pending entry of the same id and inserts the task ahead of the
// first entry whose time is at or above its own; it gives no result. A tick item (func 1)
// releases every head entry whose time plus time_base (wrapping at 32 bits) is at or below
// current_tick, one rsp item per task, with last set on the final one. One item is worked
// on at a time and req_ready is low meanwhile. A single 32-bit compare unit serves the
// position scan and the head due check; the list is walked one entry per cycle: an enqueue
// makes an id scan, then a position scan, and a tick removes released tasks from the head,
// stalling while rsp_ready is low. The list itself shifts in one registered update on insert and removal.
`include "delayed_task_release_queue_unit_defines.svh"

module delayed_task_release_queue_unit import dtrq_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [TimeW-1:0] csr_wdata
);

   localparam logic [1:0] StIdle  = 2'd0;
   localparam logic [1:0] StFind  = 2'd1;
   localparam logic [1:0] StPlace = 2'd2;
   localparam logic [1:0] StTick  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [CountW-1:0]  idx_ff, idx_in;
   logic [CountW-1:0]  count_ff, count_in;
   req_type            item_ff, item_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [TaskIdW-1:0] pend_id_ff, pend_id_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;
   logic [TimeW-1:0]   base_ff, base_in;

   list_cmd_type       cmd;
   logic [TaskIdW-1:0] rd_id;
   logic [TimeW-1:0]   rd_time;
   logic [TaskIdW-1:0] head_id;
   logic [TimeW-1:0]   head_time;

   logic               scan_live;
   logic               out_free;
   logic [TimeW-1:0]   cmp_a;
   logic [TimeW-1:0]   cmp_b;
   logic               cmp_le;
   logic               head_due;

   dtrq_list u_list (
      .clock     (clock),
      .cmd       (cmd),
      .rd_idx    (idx_ff[IdxW-1:0]),
      .rd_id     (rd_id),
      .rd_time   (rd_time),
      .head_id   (head_id),
      .head_time (head_time)
   );

   assign req_ready = (state_ff == StIdle);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign scan_live = (idx_ff < count_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // shared compare: insertion position search, or head due check on a tick
   assign cmp_a    = (state_ff == StPlace) ? item_ff.arrival_time : head_time + base_ff;
   assign cmp_b    = (state_ff == StPlace) ? rd_time : item_ff.current_tick;
   assign cmp_le   = (cmp_a <= cmp_b);
   assign head_due = (count_ff != '0) && cmp_le;

   assign base_in = csr_we ? csr_wdata : base_ff;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      item_in       = item_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      cmd.op        = ListNop;
      cmd.pos       = '0;
      cmd.id        = item_ff.task_id;
      cmd.stamp     = item_ff.arrival_time;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               item_in = req_data;
               if (req_data.func == FuncTick) begin
                  pend_valid_in = 1'b0;
                  state_in      = StTick;
               end else if (int'(req_data.task_id) < MaxTasks) begin
                  idx_in   = '0;
                  state_in = StFind;
               end
            end
         end
         StFind: begin
            if (!scan_live) begin
               idx_in   = '0;
               state_in = StPlace;
            end else if (rd_id == item_ff.task_id) begin
               // drop the old entry before placing the new one
               cmd.op   = ListRemove;
               cmd.pos  = idx_ff[IdxW-1:0];
               count_in = count_ff - 1'b1;
               idx_in   = '0;
               state_in = StPlace;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         StPlace: begin
            if (!scan_live || cmp_le) begin
               if (count_ff < CountW'(MaxTasks)) begin
                  cmd.op   = ListInsert;
                  cmd.pos  = idx_ff[IdxW-1:0];
                  count_in = count_ff + 1'b1;
               end
               state_in = StIdle;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         StTick: begin
            // one task is held back so that the final one can carry last
            if (pend_valid_ff) begin
               if (out_free) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.started_task = pend_id_ff;
                  if (head_due) begin
                     rsp_in.last = 1'b0;
                     pend_id_in  = head_id;
                     cmd.op      = ListRemove;
                     cmd.pos     = '0;
                     count_in    = count_ff - 1'b1;
                  end else begin
                     rsp_in.last   = 1'b1;
                     pend_valid_in = 1'b0;
                     state_in      = StIdle;
                  end
               end
            end else if (head_due) begin
               pend_valid_in = 1'b1;
               pend_id_in    = head_id;
               cmd.op        = ListRemove;
               cmd.pos       = '0;
               count_in      = count_ff - 1'b1;
            end else begin
               state_in = StIdle;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         base_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         base_ff       <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      item_ff    <= item_in;
      pend_id_ff <= pend_id_in;
      rsp_ff     <= rsp_in;
   end

   `DTRQ_ASSERT_IMP(a_count_max, clock, reset, 1'b1, count_ff <= CountW'(MaxTasks))
   `DTRQ_ASSERT_NEXT(a_count_step, clock, reset, 1'b1, count_ff == $past(count_ff) || count_ff == $past(count_ff) + 1'b1 || count_ff == $past(count_ff) - 1'b1)
   `DTRQ_ASSERT_IMP(a_pend_in_tick, clock, reset, pend_valid_ff, state_ff == StTick)
   `DTRQ_ASSERT_NEXT(a_last_flag, clock, reset, state_ff == StTick && pend_valid_ff && out_free && !head_due, rsp_valid_ff && rsp_ff.last && state_ff == StIdle)

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
   import dtrq_pkg::*;

   localparam int CycleLimit = 1000000;
   // an enqueue walks the list twice, so a full list keeps the block busy a while
   localparam int DrainCycles = 2 * MaxTasks + 8;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_we;
   logic [TimeW-1:0] csr_wdata;

   delayed_task_release_queue_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // mirror of the release list and the time base
   logic [TaskIdW-1:0] model_ids [MaxTasks];
   logic [TimeW-1:0]   model_times [MaxTasks];
   int                 model_count;
   logic [TimeW-1:0]   model_base;

   rsp_type due_releases [$];
   int      failures;
   int      cycle_count;
   bit      req_gaps;
   bit      rsp_gaps;
   int      stall_left;

   always #6 clock = ~clock;

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic void drop_entry(int pos);
      for (int k = pos; k + 1 < model_count; k++) begin
         model_ids[k]   = model_ids[k + 1];
         model_times[k] = model_times[k + 1];
      end
      model_count--;
   endfunction

   function automatic bit head_due(logic [TimeW-1:0] now);
      logic [TimeW-1:0] due;
      due = model_times[0] + model_base;
      return model_count > 0 && due <= now;
   endfunction

   function automatic void predict_releases(req_type item);
      int      hit;
      int      pos;
      rsp_type out;
      if (item.func == FuncEnqueue) begin
         hit = -1;
         for (int k = 0; k < model_count; k++)
            if (hit < 0 && model_ids[k] == item.task_id) hit = k;
         if (hit >= 0) drop_entry(hit);
         pos = model_count;
         for (int k = model_count - 1; k >= 0; k--)
            if (item.arrival_time <= model_times[k]) pos = k;
         if (model_count < MaxTasks) begin
            for (int k = model_count; k > pos; k--) begin
               model_ids[k]   = model_ids[k - 1];
               model_times[k] = model_times[k - 1];
            end
            model_ids[pos]   = item.task_id;
            model_times[pos] = item.arrival_time;
            model_count++;
         end
      end else begin
         while (head_due(item.current_tick)) begin
            out.started_task = model_ids[0];
            drop_entry(0);
            out.last = !head_due(item.current_tick);
            due_releases.push_back(out);
         end
      end
   endfunction

   task automatic send_item(input req_type item);
      int gap;
      gap = req_gaps ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      predict_releases(item);
   endtask

   task automatic send_enqueue(input logic [TaskIdW-1:0] id, input logic [TimeW-1:0] t);
      req_type item;
      item.func         = FuncEnqueue;
      item.task_id      = id;
      item.arrival_time = t;
      item.current_tick = $urandom;
      send_item(item);
   endtask

   task automatic send_tick(input logic [TimeW-1:0] now);
      req_type item;
      item.func         = FuncTick;
      item.task_id      = TaskIdW'($urandom_range(0, 15));
      item.arrival_time = $urandom;
      item.current_tick = now;
      send_item(item);
   endtask

   task automatic set_time_base(input logic [TimeW-1:0] value);
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_releases.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      model_base = value;
   endtask

   task automatic test_empty_tick();
      send_tick('0);
      send_tick('1);
   endtask

   // equal times put the newest first, a pending id moves to its new place
   task automatic test_ordering();
      send_enqueue(4'd5, 32'd100);
      send_enqueue(4'd7, 32'd100);
      send_enqueue(4'd0, 32'd0);
      send_enqueue(4'd9, 32'hFFFF_FFFF);
      send_enqueue(4'd5, 32'd50);
      send_tick(32'd0);
      send_tick(32'd100);
   endtask

   task automatic test_full_queue();
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      for (int id = 0; id < MaxTasks; id++)
         if (id != 9) send_enqueue(id[TaskIdW-1:0], $urandom_range(0, 3));
      send_tick('1);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
   endtask

   // stored time plus base wraps; a head that is not due holds back later entries
   task automatic test_wrap_compare();
      set_time_base(32'hFFFF_FFF0);
      send_enqueue(4'd3, 32'h20);
      send_enqueue(4'd4, 32'd5);
      send_tick(32'h10);
      send_tick('1);
   endtask

   task automatic test_random_traffic(input logic [TimeW-1:0] base, input int count);
      int               roll;
      logic [TimeW-1:0] now;
      set_time_base(base);
      now = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FF80 : $urandom;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 45)
            send_enqueue(TaskIdW'($urandom_range(0, 15)),
                         now - model_base + $urandom_range(0, 80));
         else if (roll < 55)
            send_enqueue(TaskIdW'($urandom_range(0, 15)), $urandom);
         else if (roll < 93) begin
            now = now + $urandom_range(0, 50);
            send_tick(now);
         end else
            send_tick($urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom);
      end
   endtask

   always @(negedge clock) begin : rsp_pacing
      int n;
      if (!rsp_gaps) begin
         stall_left = 0;
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         n = pick_gap();
         stall_left = (n > 0) ? n - 1 : 0;
         rsp_ready <= (n == 0);
      end
   end

   always @(posedge clock) begin : release_check
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (due_releases.size() == 0) begin
            $error("unexpected item: started_task %0d last %0d",
                   rsp_data.started_task, rsp_data.last);
            failures++;
         end else begin
            want = due_releases.pop_front();
            if (rsp_data.started_task !== want.started_task) begin
               $error("started_task expected %0d actual %0d",
                      want.started_task, rsp_data.started_task);
               failures++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last expected %0d actual %0d", want.last, rsp_data.last);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      clock       = 1'b0;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      req_gaps    = 1'b1;
      rsp_gaps    = 1'b1;
      stall_left  = 0;
      failures    = 0;
      cycle_count = 0;
      model_count = 0;
      model_base  = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_tick();
      test_ordering();
      test_full_queue();
      test_wrap_compare();
      test_random_traffic('1, 56);
      test_random_traffic('0, 56);
      test_random_traffic($urandom, 56);
      test_random_traffic($urandom_range(1, 200), 56);

      @(negedge clock);
      req_valid <= 1'b0;
      while (due_releases.size() != 0) @(negedge clock);
      repeat (DrainCycles) @(negedge clock);
      if (failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
